// ----- rtl/bff_pkg.sv -----
package bff_pkg;
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_QUERY  = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [0:0] REG_NUM_HASHES  = 1'd0;
  localparam logic [0:0] REG_FILTER_BITS = 1'd1;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  function automatic logic [31:0] fnv_byte(input logic [31:0] h, input logic [7:0] b);
    fnv_byte = (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] seed_state(input logic [31:0] s);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int k = 0; k < 4; k++) h = fnv_byte(h, s[8*k +: 8]);
    seed_state = h;
  endfunction
endpackage

// ----- rtl/bff_ram.sv -----
module bff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/bff_mod.sv -----
// Sequential restoring remainder of a 32-bit hash by the modulus, one bit a cycle.
module bff_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [16:0] modulus,
  output logic        done,
  output logic [16:0] remainder
);
  logic [31:0] shreg;
  logic [17:0] rem;
  logic [5:0]  count;
  logic        running;
  logic [17:0] trial;

  assign trial = {rem[16:0], shreg[31]} - {1'b0, modulus};
  assign remainder = rem[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count <= 6'd32;
        rem <= '0;
        shreg <= dividend;
      end else if (running) begin
        shreg <= {shreg[30:0], 1'b0};
        if (!trial[17]) rem <= trial;
        else rem <= {rem[16:0], shreg[31]};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/bloom_filter_fnv1a_top.sv -----
// Bloom filter with seeded FNV-1a 32 hashes over a bit store held in a byte RAM.
// Issue an item by raising start while busy is low; it is taken at that edge.
// Key bytes (insert or query) update all hash lanes; a byte without the last
// mark passes through a wait state. On the last byte each of the active lanes
// in turn is reduced by a bit-serial remainder unit and its filter byte read,
// then set (insert) or tested (query); after the active lanes a done state
// finishes the key and shows its result. A write passes through a wait state;
// a read passes through a read state, which registers its result.
// Clear sweeps every RAM byte, one a cycle.
// Insert and query end with one result, read with one; each result is shown
// for one cycle with strobe high, and the receiver cannot stall it.
// After reset the block runs the same clearing sweep before it takes an item;
// configuration writes through cfg_we are taken at any time.
module bloom_filter_fnv1a_top #(
  parameter int FILTER_BITS = 4096,
  parameter int MAX_HASHES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [8:0]  byte_index,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        strobe,
  output logic [1:0]  result_kind,
  output logic        hit,
  output logic [7:0]  filter_byte
);
  import bff_pkg::*;

  localparam int BYTES = (FILTER_BITS + 7) / 8;
  localparam int AW = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001, S_IDLE = 8'b00000010, S_MOD = 8'b00000100,
    S_RD = 8'b00001000, S_RMW = 8'b00010000, S_DONE = 8'b00100000,
    S_READ = 8'b01000000, S_WAIT = 8'b10000000
  } state_t;

  state_t state;
  logic [3:0]  num_hashes;
  logic [12:0] filter_bits;
  logic [31:0] lanes [MAX_HASHES];
  logic [HW:0] probe;
  logic [HW:0] nh;
  logic [16:0] modulus;
  logic        is_insert, hit_acc;
  logic [AW:0] sweep;
  logic        mod_go, mod_done;
  logic [16:0] pos;
  logic        pos_ok;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  wdata, rdata;
  logic        rd_ok;
  opcode_t     op;

  assign op = opcode_t'(opcode);
  assign busy = (state != S_IDLE);

  always_comb begin
    if ({28'd0, num_hashes} > MAX_HASHES) nh = (HW+1)'(MAX_HASHES);
    else nh = (HW+1)'(num_hashes);
    if (filter_bits == 13'd0 || {19'd0, filter_bits} > FILTER_BITS)
      modulus = 17'(FILTER_BITS);
    else modulus = {4'd0, filter_bits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_hashes <= 4'd6;
      filter_bits <= 13'd4096;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_HASHES) num_hashes <= cfg_data[3:0];
      else filter_bits <= cfg_data;
    end
  end

  bff_mod u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .dividend(lanes[probe[HW-1:0]]),
    .modulus(modulus), .done(mod_done), .remainder(pos)
  );

  assign pos_ok = ({15'd0, pos} < FILTER_BITS);

  bff_ram #(.WIDTH(8), .DEPTH(BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    we = 1'b0;
    waddr = pos[AW+2:3];
    wdata = rdata | (8'd1 << pos[2:0]);
    raddr = pos[AW+2:3];
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = sweep[AW-1:0];
      wdata = 8'd0;
    end else if (state == S_IDLE) begin
      raddr = AW'({3'd0, byte_index});
      if (start && op == OP_WRITE && {23'd0, byte_index} < BYTES) begin
        we = 1'b1;
        waddr = AW'({3'd0, byte_index});
        wdata = data_byte;
      end
    end else if (state == S_RMW) begin
      we = is_insert && pos_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      strobe <= 1'b0;
      mod_go <= 1'b0;
      for (int i = 0; i < MAX_HASHES; i++) lanes[i] <= seed_state(32'(i));
    end else begin
      strobe <= 1'b0;
      mod_go <= 1'b0;
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (AW+1)'(BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          case (op)
            OP_INSERT, OP_QUERY: begin
              for (int i = 0; i < MAX_HASHES; i++) lanes[i] <= fnv_byte(lanes[i], data_byte);
              is_insert <= (op == OP_INSERT);
              hit_acc <= 1'b1;
              probe <= '0;
              if (last_byte) state <= S_MOD;
              else state <= S_WAIT;
            end
            OP_CLEAR: begin
              for (int i = 0; i < MAX_HASHES; i++) lanes[i] <= seed_state(32'(i));
              sweep <= '0;
              state <= S_CLEAR;
            end
            OP_WRITE: state <= S_WAIT;
            OP_READ: begin
              rd_ok <= ({23'd0, byte_index} < BYTES);
              state <= S_READ;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_WAIT: state <= S_IDLE;
        S_READ: begin
          strobe <= 1'b1;
          result_kind <= KIND_READ;
          hit <= 1'b0;
          filter_byte <= rd_ok ? rdata : 8'd0;
          state <= S_IDLE;
        end
        S_MOD: begin
          if (probe == nh) state <= S_DONE;
          else begin
            mod_go <= 1'b1;
            state <= S_RD;
          end
        end
        S_RD: if (mod_done) state <= S_RMW;
        S_RMW: begin
          if (!is_insert && !(pos_ok && rdata[pos[2:0]])) hit_acc <= 1'b0;
          probe <= probe + 1'b1;
          state <= S_MOD;
        end
        S_DONE: begin
          strobe <= 1'b1;
          result_kind <= is_insert ? KIND_INSERT : KIND_QUERY;
          hit <= !is_insert && hit_acc;
          filter_byte <= 8'd0;
          for (int i = 0; i < MAX_HASHES; i++) lanes[i] <= seed_state(32'(i));
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The remainder finishes while the probe waits in S_RD, in the cycle before its RAM byte is consumed.
  a_done_in_rd: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_RD) else $error("remainder done outside probe wait");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW && we) |-> is_insert) else $error("query wrote the store");
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("result held for two cycles");
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bff_pkg::*;

  localparam int STORE_BITS = 4096;
  localparam int LANES = 8;
  localparam int SETTLE_CYCLES = 600;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit;
    logic [7:0] fbyte;
  } answer_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       last;
    logic [8:0] idx;
    logic       fixed;
    answer_t    ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  opcode = OP_INSERT;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [8:0]  byte_index = '0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_NUM_HASHES;
  logic [12:0] cfg_data = '0;
  logic        busy, strobe, hit;
  logic [1:0]  result_kind;
  logic [7:0]  filter_byte;

  bloom_filter_fnv1a_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .data_byte(data_byte), .last_byte(last_byte), .byte_index(byte_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .result_kind(result_kind), .hit(hit), .filter_byte(filter_byte)
  );

  always #5 clk = ~clk;

  // Mirror of the block's state.
  logic        bits_mirror [STORE_BITS];
  logic [31:0] lane_mirror [LANES];
  logic [3:0]  hash_count;
  logic [12:0] modulus_reg;
  answer_t     answers_due[$];
  bit          failed = 1'b0;
  bit          idling = 1'b1;
  int          sent = 0;
  int unsigned cycles = 0;
  row_t        rows[$];
  logic [7:0]  key_pool [16][6];
  int          key_len [16];

  function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'd0, b}) * 32'd16777619;
  endfunction

  task automatic reseed_lanes();
    logic [31:0] h;
    for (int s = 0; s < LANES; s++) begin
      h = 32'd2166136261;
      for (int k = 0; k < 4; k++) h = fnv_mix(h, 8'(s >> (8 * k)));
      lane_mirror[s] = h;
    end
  endtask

  task automatic predict_transfer(input logic [2:0] op, input logic [7:0] data,
                                  input logic last, input logic [8:0] idx,
                                  output bit has, output answer_t a);
    int unsigned n, m, pos;
    logic all_set;
    has = 0;
    a = '0;
    all_set = 1'b1;
    if (op == OP_INSERT || op == OP_QUERY) begin
      n = (hash_count > LANES) ? LANES : hash_count;
      m = (modulus_reg == 0 || modulus_reg > STORE_BITS) ? STORE_BITS : modulus_reg;
      for (int i = 0; i < LANES; i++) lane_mirror[i] = fnv_mix(lane_mirror[i], data);
      if (last) begin
        for (int i = 0; i < n; i++) begin
          pos = lane_mirror[i] % m;
          if (op == OP_INSERT) bits_mirror[pos] = 1'b1;
          else if (!bits_mirror[pos]) all_set = 1'b0;
        end
        reseed_lanes();
        has = 1;
        a.kind = (op == OP_INSERT) ? KIND_INSERT : KIND_QUERY;
        a.hit = (op == OP_QUERY) && all_set;
      end
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < STORE_BITS; i++) bits_mirror[i] = 1'b0;
      reseed_lanes();
    end else if (op == OP_WRITE) begin
      for (int i = 0; i < 8; i++) bits_mirror[idx * 8 + i] = data[i];
    end else if (op == OP_READ) begin
      has = 1;
      a.kind = KIND_READ;
      for (int i = 0; i < 8; i++) a.fbyte[i] = bits_mirror[idx * 8 + i];
    end
  endtask

  task automatic send_transfer(input logic [2:0] op, input logic [7:0] data,
                               input logic last, input logic [8:0] idx,
                               input bit fixed, input answer_t fixed_ans);
    bit has;
    answer_t a;
    if (idling && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    data_byte <= data;
    last_byte <= last;
    byte_index <= idx;
    do @(posedge clk); while (busy);
    predict_transfer(op, data, last, idx, has, a);
    if (has) answers_due.push_back(fixed ? fixed_ans : a);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] which, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (which == REG_NUM_HASHES) hash_count = val[3:0];
    else modulus_reg = val;
  endtask

  task automatic add_row(input logic [2:0] op, input logic [7:0] data, input logic last,
                         input logic [8:0] idx, input bit fixed, input answer_t a);
    rows.push_back('{op, data, last, idx, fixed, a});
  endtask

  task automatic random_key();
    int slot, len;
    logic [2:0] op;
    bit mixed;
    slot = $urandom_range(0, 15);
    if ($urandom_range(0, 1) == 0 || key_len[slot] == 0) begin
      key_len[slot] = $urandom_range(1, 6);
      for (int i = 0; i < 6; i++) key_pool[slot][i] = 8'($urandom);
    end
    len = key_len[slot];
    mixed = ($urandom_range(0, 9) == 0);
    op = $urandom_range(0, 1) ? OP_QUERY : OP_INSERT;
    for (int i = 0; i < len; i++)
      send_transfer((mixed && $urandom_range(0, 1)) ? OP_QUERY - op : op,
                    key_pool[slot][i], i == len - 1, 9'($urandom), 0, '0);
  endtask

  task automatic random_phase(input int upto);
    int pick;
    while (sent < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) random_key();
      else if (pick < 74) send_transfer(OP_WRITE, 8'($urandom), 1'($urandom),
                                        9'($urandom), 0, '0);
      else if (pick < 90) send_transfer(OP_READ, 8'($urandom), 1'($urandom),
                                        9'($urandom), 0, '0);
      else if (pick < 95)
        // A stray key byte leaves a partial key open for whatever follows.
        send_transfer(3'($urandom_range(0, 1)), 8'($urandom), 1'b0,
                      9'($urandom), 0, '0);
      else if (pick < 97) send_transfer(OP_CLEAR, 8'($urandom), 1'($urandom),
                                        9'($urandom), 0, '0);
      else send_transfer(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 8'($urandom),
                         1'($urandom), 9'($urandom), 0, '0);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && strobe) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result kind %0d hit %0d byte %02h", $time,
                 result_kind, hit, filter_byte);
        failed = 1'b1;
      end else begin
        want = answers_due.pop_front();
        if (result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, result_kind);
          failed = 1'b1;
        end
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
          failed = 1'b1;
        end
        if (filter_byte !== want.fbyte) begin
          $display("%0t: filter_byte expected %02h actual %02h", $time, want.fbyte,
                   filter_byte);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    answer_t none;
    none = '0;
    for (int i = 0; i < STORE_BITS; i++) bits_mirror[i] = 1'b0;
    reseed_lanes();
    hash_count = 4'd6;
    modulus_reg = 13'd4096;
    for (int i = 0; i < 16; i++) key_len[i] = 0;

    // Empty store after reset, then the extremes of the byte address.
    add_row(OP_READ, 8'h00, 1'b0, 9'd0, 1, '{KIND_READ, 1'b0, 8'h00});
    add_row(OP_READ, 8'hFF, 1'b1, 9'd511, 1, '{KIND_READ, 1'b0, 8'h00});
    add_row(OP_QUERY, 8'h61, 1'b1, 9'd0, 1, '{KIND_QUERY, 1'b0, 8'h00});
    add_row(OP_WRITE, 8'hFF, 1'b0, 9'd5, 0, none);
    add_row(OP_READ, 8'h00, 1'b0, 9'd5, 1, '{KIND_READ, 1'b0, 8'hFF});
    add_row(OP_WRITE, 8'hA5, 1'b1, 9'd511, 0, none);
    add_row(OP_READ, 8'h00, 1'b0, 9'd511, 1, '{KIND_READ, 1'b0, 8'hA5});
    add_row(OP_INSERT, 8'h00, 1'b0, 9'd0, 0, none);
    add_row(OP_INSERT, 8'hFF, 1'b1, 9'd0, 0, none);
    add_row(OP_QUERY, 8'h00, 1'b0, 9'd0, 0, none);
    add_row(OP_QUERY, 8'hFF, 1'b1, 9'd0, 0, none);
    // Writes and reads in the middle of a key leave the key alone.
    add_row(OP_INSERT, 8'h12, 1'b0, 9'd0, 0, none);
    add_row(OP_WRITE, 8'h5A, 1'b0, 9'd300, 0, none);
    add_row(OP_READ, 8'h00, 1'b0, 9'd300, 0, none);
    add_row(OP_QUERY, 8'h34, 1'b0, 9'd0, 0, none);
    add_row(OP_INSERT, 8'h56, 1'b1, 9'd0, 0, none);
    add_row(OP_SPARE_FIRST, 8'hFF, 1'b1, 9'd511, 0, none);
    add_row(OP_SPARE_LAST, 8'h00, 1'b0, 9'd0, 0, none);
    add_row(3'd6, 8'h77, 1'b1, 9'd100, 0, none);
    add_row(OP_QUERY, 8'h99, 1'b0, 9'd0, 0, none);
    add_row(OP_CLEAR, 8'h00, 1'b0, 9'd0, 0, none);
    add_row(OP_READ, 8'h00, 1'b0, 9'd5, 1, '{KIND_READ, 1'b0, 8'h00});
    add_row(OP_QUERY, 8'h56, 1'b1, 9'd0, 1, '{KIND_QUERY, 1'b0, 8'h00});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_transfer(rows[i].op, rows[i].data, rows[i].last, rows[i].idx,
                    rows[i].fixed, rows[i].ans);
    random_phase(200);

    drain();
    write_reg(REG_NUM_HASHES, 13'd1);
    write_reg(REG_FILTER_BITS, 13'd8);
    random_phase(400);
    drain();
    write_reg(REG_NUM_HASHES, 13'd8);
    write_reg(REG_FILTER_BITS, 13'd4096);
    random_phase(600);
    drain();
    // Zero hashes makes every query a hit; zero modulus falls back to the full store.
    write_reg(REG_NUM_HASHES, 13'd0);
    write_reg(REG_FILTER_BITS, 13'd0);
    random_phase(750);
    drain();
    write_reg(REG_NUM_HASHES, 13'h1FFF);
    write_reg(REG_FILTER_BITS, 13'h1FFF);
    random_phase(950);
    drain();
    write_reg(REG_NUM_HASHES, 13'd3);
    write_reg(REG_FILTER_BITS, 13'd100);
    random_phase(1150);
    drain();
    write_reg(REG_NUM_HASHES, 13'd2);
    write_reg(REG_FILTER_BITS, 13'd13);
    random_phase(1250);
    idling = 1'b0;
    random_phase(1420);

    drain();
    if (!failed) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
